// ===== hw/rtl/srcg_pkg.sv =====
// srcg_pkg: types and constants shared by the split ring chain gather block
// no dependencies

package srcg_pkg;

   localparam int unsigned OpW = 3;

   typedef enum logic [2:0] {
      OP_WR_DESC  = 3'd0,
      OP_WR_AVAIL = 3'd1,
      OP_MARK_RDY = 3'd2,
      OP_SET_LIM  = 3'd3,
      OP_SCAN     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_REC     = 3'd0,
      KIND_SUMMARY = 3'd1,
      KIND_NONE    = 3'd2,
      KIND_INDIR   = 3'd3,
      KIND_LONG    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HEAD,
      ST_FETCH,
      ST_DESC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  entry_index;
      logic [63:0] buffer_addr;
      logic [31:0] buffer_len;
      logic [2:0]  desc_flags;
      logic [7:0]  link_index;
      logic [15:0] limit_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  slot;
      logic [7:0]  head_index;
      logic        is_write;
      logic [3:0]  vector_pos;
      logic [63:0] rec_addr;
      logic [31:0] rec_len;
      logic [4:0]  desc_count;
      logic [4:0]  read_count;
      logic [15:0] read_bytes;
      logic [15:0] write_bytes;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/srcg_ram.sv =====
// srcg_ram: generic simple dual port ram, one write and one registered read
// no dependencies

module srcg_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/srcg_front.sv =====
// srcg_front: accepts requests with a known opcode and queues them for the back end
// depends on srcg_pkg

module srcg_front #(
   parameter int unsigned QDepth = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_start,
   input  srcg_pkg::req_type req_data,
   output logic            busy,
   input  logic            pop,
   output logic            q_valid,
   output srcg_pkg::req_type q_data
);
   import srcg_pkg::*;

   localparam int unsigned AW = $clog2(QDepth);

   req_type         q_ff [QDepth];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push;

   assign busy    = (cnt_ff == (AW+1)'(QDepth));
   assign push    = req_start && !busy && (req_data.opcode <= OP_SCAN);
   assign q_valid = (cnt_ff != '0);
   assign q_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = (pop && q_valid) ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= req_data;
      end
   end

endmodule

// ===== hw/rtl/srcg_back.sv =====
// srcg_back: table storage and descriptor chain walk
// depends on srcg_pkg and srcg_ram

module srcg_back #(
   parameter int unsigned RingDepth = 256,
   parameter int unsigned MaxChain  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        ring_size_log2,
   input  logic              q_valid,
   input  srcg_pkg::req_type q_data,
   output logic              pop,
   output logic              rsp_strobe,
   output srcg_pkg::rsp_type rsp_data
);
   import srcg_pkg::*;

   localparam int unsigned IW = $clog2(RingDepth);
   localparam int unsigned CW = $clog2(MaxChain + 1);

   state_type      st_ff, st_in;
   req_type        cur;
   logic [IW-1:0]  ei;
   logic [IW-1:0]  sidx;
   logic [7:0]     slot8;
   logic [7:0]     mask;
   logic [3:0]     lg;
   logic [RingDepth-1:0] rdy_ff;
   logic           rdy_rd_ff;
   logic [15:0]    cons_ff, lim_ff;
   logic [7:0]     head_ff, cur_ff, cur_in;
   logic [CW-1:0]  n_ff;
   logic [4:0]     rc_ff, wc_ff;
   logic [15:0]    rb_ff, wb_ff;
   logic           rsp_v_ff, rsp_v_in;
   rsp_type        rsp_ff, rsp_in;
   logic           wr_desc, wr_av;
   logic [IW-1:0]  drd;
   logic [63:0]    d_addr;
   logic [31:0]    d_len;
   logic [10:0]    d_ctl;
   logic [7:0]     av_head;
   logic           take;
   logic           sum_pend_ff;
   rsp_type        sum_ff, sum_in;
   rsp_type        sum_out;
   logic           sum_show_ff;
   rsp_type        sum_hold_ff;

   assign cur   = q_data;
   assign ei    = IW'(q_data.entry_index);
   assign lg    = (ring_size_log2 < 4'd1) ? 4'd1 :
                  (ring_size_log2 > 4'd8) ? 4'd8 : ring_size_log2;
   assign mask  = 8'((9'd1 << lg) - 9'd1);
   assign slot8 = cons_ff[7:0] & mask;
   assign sidx  = IW'(slot8);
   assign take  = q_valid && (st_ff == ST_IDLE);
   assign wr_desc = take && (cur.opcode == OP_WR_DESC);
   assign wr_av   = take && (cur.opcode == OP_WR_AVAIL);
   assign drd     = IW'(cur_ff);

   srcg_ram #(.Width(64), .Depth(RingDepth)) u_addr (
      .clock, .wr_en(wr_desc), .wr_addr(ei), .wr_data(cur.buffer_addr),
      .rd_addr(drd), .rd_data(d_addr));
   srcg_ram #(.Width(32), .Depth(RingDepth)) u_len (
      .clock, .wr_en(wr_desc), .wr_addr(ei), .wr_data(cur.buffer_len),
      .rd_addr(drd), .rd_data(d_len));
   srcg_ram #(.Width(11), .Depth(RingDepth)) u_ctl (
      .clock, .wr_en(wr_desc), .wr_addr(ei),
      .wr_data({cur.link_index, cur.desc_flags}),
      .rd_addr(drd), .rd_data(d_ctl));
   srcg_ram #(.Width(8), .Depth(RingDepth)) u_av (
      .clock, .wr_en(wr_av), .wr_addr(ei), .wr_data(cur.link_index),
      .rd_addr(sidx), .rd_data(av_head));

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (take && cur.opcode == OP_SCAN) st_in = ST_CHECK;
         ST_CHECK: st_in = (lim_ff == cons_ff || !rdy_rd_ff) ? ST_IDLE : ST_HEAD;
         ST_HEAD:  st_in = ST_FETCH;
         ST_FETCH: st_in = ST_DESC;
         ST_DESC: begin
            if (d_ctl[2] || !d_ctl[0] || n_ff + 1'b1 >= CW'(MaxChain)) begin
               st_in = ST_IDLE;
            end else begin
               st_in = ST_FETCH;
            end
         end
         default:  st_in = ST_IDLE;
      endcase
   end

   assign pop = take;

   // next descriptor index
   always_comb begin
      cur_in = cur_ff;
      if (st_ff == ST_HEAD) cur_in = av_head;
      if (st_ff == ST_DESC) cur_in = d_ctl[10:3];
   end

   always_comb begin
      rsp_v_in     = 1'b0;
      rsp_in       = '0;
      rsp_in.slot  = slot8;
      sum_in       = sum_ff;
      if (st_ff == ST_CHECK) begin
         rsp_v_in    = (st_in == ST_IDLE);
         rsp_in.kind = KIND_NONE;
         rsp_in.last = 1'b1;
      end
      if (st_ff == ST_DESC) begin
         rsp_v_in          = 1'b1;
         rsp_in.head_index = head_ff;
         if (d_ctl[2]) begin
            rsp_in.kind        = KIND_INDIR;
            rsp_in.last        = 1'b1;
            rsp_in.desc_count  = 5'(n_ff);
            rsp_in.read_count  = rc_ff;
            rsp_in.read_bytes  = rb_ff;
            rsp_in.write_bytes = wb_ff;
         end else begin
            rsp_in.kind       = KIND_REC;
            rsp_in.is_write   = d_ctl[1];
            rsp_in.vector_pos = d_ctl[1] ? wc_ff[3:0] : rc_ff[3:0];
            rsp_in.rec_addr   = d_addr;
            rsp_in.rec_len    = d_len;
            sum_in            = '0;
            sum_in.kind       = d_ctl[0] ? KIND_LONG : KIND_SUMMARY;
            sum_in.slot       = slot8;
            sum_in.head_index = head_ff;
            sum_in.last       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rdy_ff   <= '0;
         cons_ff  <= '0;
         lim_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         rsp_v_ff <= rsp_v_in;
         if (take && cur.opcode == OP_MARK_RDY) rdy_ff[ei] <= 1'b1;
         if (take && cur.opcode == OP_SET_LIM)  lim_ff <= cur.limit_value;
         if (st_ff == ST_DESC && !d_ctl[2] && st_in == ST_IDLE) begin
            rdy_ff[sidx] <= 1'b0;
            cons_ff      <= cons_ff + 16'd1;
         end
      end
   end

   // summary shown in the cycle after the last record
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_pend_ff <= 1'b0;
      end else begin
         sum_pend_ff <= (st_ff == ST_DESC) && !d_ctl[2] && (st_in == ST_IDLE);
      end
      cur_ff    <= cur_in;
      rdy_rd_ff <= rdy_ff[sidx];
      rsp_ff    <= rsp_in;
      sum_ff    <= sum_in;
      if (st_ff == ST_HEAD) begin
         head_ff <= av_head;
         n_ff    <= '0;
         rc_ff   <= '0;
         wc_ff   <= '0;
         rb_ff   <= '0;
         wb_ff   <= '0;
      end
      if (st_ff == ST_DESC && !d_ctl[2]) begin
         n_ff <= n_ff + 1'b1;
         if (d_ctl[1]) begin
            wc_ff <= wc_ff + 5'd1;
            wb_ff <= wb_ff + d_len[15:0];
         end else begin
            rc_ff <= rc_ff + 5'd1;
            rb_ff <= rb_ff + d_len[15:0];
         end
      end
   end

   // counts are final in the same cycle as the last record is shown
   always_comb begin
      sum_out = sum_ff;
      sum_out.desc_count  = 5'(n_ff);
      sum_out.read_count  = rc_ff;
      sum_out.read_bytes  = rb_ff;
      sum_out.write_bytes = wb_ff;
   end

   // record of the next scan never starts before summary slot
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_show_ff <= 1'b0;
      end else begin
         sum_show_ff <= sum_pend_ff;
      end
      sum_hold_ff <= sum_out;
   end

   assign rsp_strobe = rsp_v_ff || sum_show_ff;
   assign rsp_data   = sum_show_ff ? sum_hold_ff : rsp_ff;

endmodule

// ===== hw/rtl/split_ring_chain_gather.sv =====
// split_ring_chain_gather: top level, front queue and chain walk back end
// depends on srcg_pkg, srcg_front, srcg_back
// order with an idle back end: a request passes the front queue; a table op takes
// effect when the back end takes it; a scan checks limit and ready bit and ends there
// if nothing is ready, else reads the head, then walks a fetch and a desc state per
// descriptor, with the summary in the cycle after the last record; throughput: one
// table op per cycle while the back end is idle; busy while the 4-entry queue is full
// reset: synchronous, clears ready bits, indexes and queue; tables not cleared
// the receiver cannot stall results

module split_ring_chain_gather #(
   parameter int unsigned RING_DEPTH = 256,
   parameter int unsigned MAX_CHAIN  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srcg_pkg::req_type req_data,
   output logic              rsp_strobe,
   output srcg_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data
);
   import srcg_pkg::*;

   logic       q_valid, pop;
   req_type    q_data;
   logic [3:0] lg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff <= 4'd8;
      end else if (csr_wr_en) begin
         lg_ff <= csr_wr_data;
      end
   end

   srcg_front #(.QDepth(4)) u_front (
      .clock, .reset, .req_start(start), .req_data, .busy,
      .pop, .q_valid, .q_data);

   srcg_back #(.RingDepth(RING_DEPTH), .MaxChain(MAX_CHAIN)) u_back (
      .clock, .reset, .ring_size_log2(lg_ff), .q_valid, .q_data, .pop,
      .rsp_strobe, .rsp_data);

endmodule
